@@ hdl/tsa_pkg.sv @@
// Shared types and constants for the timer slot allocator and period calculator.
// No dependencies; imported by the top level.
`default_nettype none

package tsa_pkg;

	// Request modes
	localparam logic [1:0] MODE_INIT    = 2'd0;
	localparam logic [1:0] MODE_SET     = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;
	localparam logic [1:0] MODE_QUERY   = 2'd3;

	// Result status codes
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_BAD_ID    = 3'd1;
	localparam logic [2:0] STAT_IN_USE    = 3'd2;
	localparam logic [2:0] STAT_NOT_INIT  = 3'd3;
	localparam logic [2:0] STAT_BAD_UNIT  = 3'd4;
	localparam logic [2:0] STAT_RANGE     = 3'd5;

	// Accepted time unit exponents
	localparam logic [3:0] UNIT_S  = 4'd0;
	localparam logic [3:0] UNIT_MS = 4'd3;
	localparam logic [3:0] UNIT_US = 4'd6;
	localparam logic [3:0] UNIT_NS = 4'd9;

	localparam int unsigned CYCLE_W    = 10;
	localparam int unsigned NS_W       = 64;
	localparam int unsigned BASE_W     = 42;  // cycle_ns * (2^32 - 1)
	localparam int unsigned QUO_W      = 32;
	localparam logic [9:0]  CYCLE_RST  = 10'd25;
	localparam logic [2:0]  PRESC_MAX  = 3'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CHECK,
		ST_SCALE,
		ST_BASE,
		ST_RANGE,
		ST_PSEL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} tsa_state_t;

	// Prescaler 1, 8, 64, 256 as shift amounts
	function automatic logic [3:0] presc_shift(input logic [1:0] code);
		logic [3:0] sh;
		begin
			unique case (code)
				2'd0: sh = 4'd0;
				2'd1: sh = 4'd3;
				2'd2: sh = 4'd6;
				default: sh = 4'd8;
			endcase
			return sh;
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/timer_slot_allocator_period_calc.sv @@
// Timer slot allocator with iterative period calculator (top level).
// Depends on tsa_pkg for codes, widths and the sequencer state type.
`default_nettype none

// Usage
//   A request transaction is taken at a rising edge with start high and busy low:
//   mode, timer_id, req_time and time_unit are captured there. busy stays high
//   until the result has been shown. Each request yields one result, present on
//   status, prescaler_code, period_count, wide_timer and slot_free for exactly one
//   cycle while done is high; the receiver cannot stall it, so take it then.
//   cycle_ns is written with cfg_wr_en/cfg_wr_data; the user must do this only
//   while the block is idle, as the block itself does not enforce it.
// Sequencing
//   Query, release and any request rejected at decode pass the decode step and
//   then raise done. A period calculation runs under a small sequencer: one
//   decode and one check step, up to nine multiply-by-ten steps (9 - time_unit)
//   plus one exit step, one limit step, one range step, up to four prescaler
//   compares, one load step and 32 steps of a bit-serial restoring divider,
//   then done. A new request may be accepted at the edge that ends the cycle
//   after done.
// Reset
//   arst_n clears all slots to free and not initialised and cycle_ns to 25.
module timer_slot_allocator_period_calc
	import tsa_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [3:0]  timer_id,
	input  wire logic [31:0] req_time,
	input  wire logic [3:0]  time_unit,
	input  wire logic        cfg_wr_en,
	input  wire logic [9:0]  cfg_wr_data,
	output logic             done,
	output logic [2:0]       status,
	output logic [1:0]       prescaler_code,
	output logic [31:0]      period_count,
	output logic             wide_timer,
	output logic             slot_free
);

	localparam int unsigned NUM_PAIRS = (NUM_SLOTS - 1) / 2;
	localparam int unsigned NUM_IDS   = NUM_SLOTS + NUM_PAIRS;
	localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

	// Sequencer and slot flags
	tsa_state_t             state_q, state_d;
	logic [NUM_SLOTS-1:0]   free_q, free_d;
	logic [NUM_SLOTS-1:0]   ready_q, ready_d;
	logic [CYCLE_W-1:0]     cycle_q;

	// Captured request
	logic [1:0]             mode_q, mode_d;
	logic [3:0]             id_q, id_d;
	logic [31:0]            time_q, time_d;
	logic [3:0]             unit_q, unit_d;
	logic [SLOT_W-1:0]      idx_q, idx_d;
	logic                   id_ok_q, id_ok_d;

	// Arithmetic working registers
	logic [NS_W-1:0]        acc_q, acc_d;
	logic [BASE_W-1:0]      base_q, base_d;
	logic [4:0]             cnt_q, cnt_d;
	logic [1:0]             psel_q, psel_d;
	logic [CYCLE_W-1:0]     rem_q, rem_d;
	logic [QUO_W-1:0]       quo_q, quo_d;

	// Result registers
	logic [2:0]             status_q, status_d;
	logic [1:0]             code_q, code_d;
	logic [31:0]            period_q, period_d;
	logic                   wide_q, wide_d;

	// Decode of the captured id
	logic                   dec_ok;
	logic                   dec_pair;
	logic [SLOT_W-1:0]      dec_idx;
	logic [SLOT_W-1:0]      dec_idx_hi;

	// Arithmetic operands and results
	logic [BASE_W-1:0]      cyc_ext;
	logic [NS_W-1:0]        thresh;
	logic [NS_W-1:0]        dvd;
	logic [CYCLE_W:0]       trial;
	logic [CYCLE_W:0]       trial_diff;
	logic                   unit_ok;

	always_comb begin
		dec_ok   = (32'(id_q) < NUM_IDS);
		dec_pair = (32'(id_q) >= NUM_SLOTS);
		if (dec_pair) begin
			dec_idx = SLOT_W'((32'(id_q) - NUM_SLOTS) * 2 + 1);
		end else begin
			dec_idx = SLOT_W'(id_q);
		end
		dec_idx_hi = SLOT_W'(32'(dec_idx) + 1);
	end

	assign unit_ok = (unit_q == UNIT_S) || (unit_q == UNIT_MS) ||
	                 (unit_q == UNIT_US) || (unit_q == UNIT_NS);

	assign cyc_ext    = BASE_W'(cycle_q);
	assign thresh     = NS_W'(base_q) << presc_shift(psel_q);
	assign dvd        = acc_q >> presc_shift(psel_q);
	assign trial      = {rem_q, quo_q[QUO_W-1]};
	assign trial_diff = trial - (CYCLE_W+1)'(cycle_q);

	always_comb begin
		state_d  = state_q;
		free_d   = free_q;
		ready_d  = ready_q;
		mode_d   = mode_q;
		id_d     = id_q;
		time_d   = time_q;
		unit_d   = unit_q;
		idx_d    = idx_q;
		id_ok_d  = id_ok_q;
		acc_d    = acc_q;
		base_d   = base_q;
		cnt_d    = cnt_q;
		psel_d   = psel_q;
		rem_d    = rem_q;
		quo_d    = quo_q;
		status_d = status_q;
		code_d   = code_q;
		period_d = period_q;
		wide_d   = wide_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					mode_d  = mode;
					id_d    = timer_id;
					time_d  = req_time;
					unit_d  = time_unit;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				// clear the period fields; only a finished division sets them
				code_d   = 2'd0;
				period_d = 32'd0;
				idx_d    = dec_idx;
				id_ok_d  = dec_ok;
				wide_d   = dec_ok & dec_pair;
				status_d = STAT_OK;
				state_d  = ST_DONE;
				if (!dec_ok) begin
					status_d = STAT_BAD_ID;
				end else begin
					unique case (mode_q)
						MODE_INIT: begin
							if (!free_q[dec_idx] || (dec_pair && !free_q[dec_idx_hi])) begin
								status_d = STAT_IN_USE;
							end else begin
								free_d[dec_idx]  = 1'b0;
								ready_d[dec_idx] = 1'b1;
								if (dec_pair) begin
									free_d[dec_idx_hi] = 1'b0;
								end
								state_d = ST_CHECK;
							end
						end
						MODE_SET: begin
							state_d = ST_CHECK;
						end
						MODE_RELEASE: begin
							ready_d[dec_idx] = 1'b0;
							free_d[dec_idx]  = 1'b1;
							if (dec_pair) begin
								free_d[dec_idx_hi] = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (!ready_q[idx_q]) begin
					status_d = STAT_NOT_INIT;
					state_d  = ST_DONE;
				end else if (!unit_ok) begin
					status_d = STAT_BAD_UNIT;
					state_d  = ST_DONE;
				end else begin
					acc_d   = NS_W'(time_q);
					cnt_d   = 5'(UNIT_NS - unit_q);
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				// scale to ns, one factor of ten per cycle
				if (cnt_q == 5'd0) begin
					state_d = ST_BASE;
				end else begin
					acc_d = (acc_q << 3) + (acc_q << 1);
					cnt_d = cnt_q - 5'd1;
				end
			end
			ST_BASE: begin
				// cycle_ns times the count limit of the timer width
				if (wide_q) begin
					base_d = (cyc_ext << 32) - cyc_ext;
				end else begin
					base_d = (cyc_ext << 16) - cyc_ext;
				end
				psel_d  = 2'd3;
				state_d = ST_RANGE;
			end
			ST_RANGE: begin
				// limit times 256 is the largest reachable time
				if (cycle_q == '0 || acc_q < NS_W'(cycle_q) || acc_q > thresh) begin
					status_d = STAT_RANGE;
					state_d  = ST_DONE;
				end else begin
					psel_d  = 2'd0;
					state_d = ST_PSEL;
				end
			end
			ST_PSEL: begin
				if (3'(psel_q) < PRESC_MAX && acc_q > thresh) begin
					psel_d = psel_q + 2'd1;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// quotient fits 32 bits, so the upper half is below cycle_ns
				rem_d   = CYCLE_W'(dvd[NS_W-1:QUO_W]);
				quo_d   = dvd[QUO_W-1:0];
				cnt_d   = 5'(QUO_W - 1);
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (trial >= (CYCLE_W+1)'(cycle_q)) begin
					rem_d = CYCLE_W'(trial_diff);
					quo_d = {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_d = CYCLE_W'(trial);
					quo_d = {quo_q[QUO_W-2:0], 1'b0};
				end
				cnt_d = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					status_d = STAT_OK;
					code_d   = psel_q;
					if (wide_q) begin
						period_d = quo_d;
					end else begin
						period_d = {16'd0, quo_d[15:0]};
					end
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			free_q  <= '1;
			ready_q <= '0;
			cycle_q <= CYCLE_RST;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			ready_q <= ready_d;
			if (cfg_wr_en) begin
				cycle_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q   <= mode_d;
		id_q     <= id_d;
		time_q   <= time_d;
		unit_q   <= unit_d;
		idx_q    <= idx_d;
		id_ok_q  <= id_ok_d;
		acc_q    <= acc_d;
		base_q   <= base_d;
		cnt_q    <= cnt_d;
		psel_q   <= psel_d;
		rem_q    <= rem_d;
		quo_q    <= quo_d;
		status_q <= status_d;
		code_q   <= code_d;
		period_q <= period_d;
		wide_q   <= wide_d;
	end

	// Drive the result; free flags already hold the post-request state
	assign busy           = (state_q != ST_IDLE);
	assign done           = (state_q == ST_DONE);
	assign status         = status_q;
	assign prescaler_code = code_q;
	assign period_count   = period_q;
	assign wide_timer     = wide_q;
	assign slot_free      = id_ok_q & free_q[idx_q];

endmodule

`default_nettype wire
